>>> rtl/tef_pkg.sv
// tef_pkg: shared types, widths and constants of the tile edge feather weight block.
// No dependencies; every other file of the block refers to it by scoped names.
package tef_pkg;

  localparam int unsigned MaxTile     = 1024;
  localparam int unsigned MaxGrid     = 64;

  localparam int unsigned TileIdxW    = 6;
  localparam int unsigned PixW        = 10;
  localparam int unsigned ChanW       = 16;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned SizeW       = 11;
  localparam int unsigned OvW         = 10;
  localparam int unsigned GridW       = 7;

  localparam int unsigned NumFactors  = 4;
  localparam int unsigned PairW       = 2 * OvW;
  localparam int unsigned RatioW      = NumFactors * OvW;
  localparam int unsigned ProdW       = ChanW + RatioW;
  localparam int unsigned QuoW        = ChanW;
  localparam int unsigned NumLanes    = 3;

  localparam int unsigned FrontStages = 3;
  localparam int unsigned LaneStages  = 1 + QuoW;
  localparam int unsigned PipeStages  = FrontStages + LaneStages;

  localparam int unsigned AddrW       = 4;
  localparam int unsigned DataW       = 32;

  localparam logic [SizeW-1:0] RstTileSize = 11'd256;
  localparam logic [OvW-1:0]   RstOverlap  = 10'd32;
  localparam logic [GridW-1:0] RstTileRows = 7'd1;
  localparam logic [GridW-1:0] RstTileCols = 7'd1;

  typedef enum logic [1:0] {
    RegTileSize,
    RegOverlap,
    RegTileRows,
    RegTileCols
  } reg_idx_e;

  typedef struct packed {
    logic [SizeW-1:0] tile_size;
    logic [OvW-1:0]   overlap;
    logic [GridW-1:0] tile_rows;
    logic [GridW-1:0] tile_cols;
  } cfg_t;

  typedef struct packed {
    logic [TileIdxW-1:0] tile_col;
    logic [TileIdxW-1:0] tile_row;
    logic [PixW-1:0]     pix_x;
    logic [PixW-1:0]     pix_y;
    logic [ChanW-1:0]    chan_a;
    logic [ChanW-1:0]    chan_b;
    logic [ChanW-1:0]    chan_c;
  } in_t;

  typedef struct packed {
    logic [CoordW-1:0] dest_x;
    logic [CoordW-1:0] dest_y;
    logic [ChanW-1:0]  weighted_a;
    logic [ChanW-1:0]  weighted_b;
    logic [ChanW-1:0]  weighted_c;
  } out_t;

  typedef struct packed {
    logic [CoordW-1:0] dest_x;
    logic [CoordW-1:0] dest_y;
  } coord_t;

  typedef struct packed {
    logic [RatioW-1:0] num;
    logic [RatioW-1:0] den;
  } ratio_t;

endpackage

>>> rtl/tef_cfg.sv
// tef_cfg: APB register file holding tile size, overlap and grid dimensions.
// Depends on tef_pkg.
module tef_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tef_pkg::AddrW-1:0] paddr,
  input  logic [tef_pkg::DataW-1:0] pwdata,
  output logic [tef_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output tef_pkg::cfg_t             cfg_o
);

  tef_pkg::cfg_t     cfg_q;
  tef_pkg::reg_idx_e idx;
  logic              wr;

  assign pready = 1'b1;
  assign idx    = tef_pkg::reg_idx_e'(paddr[3:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tile_size <= tef_pkg::RstTileSize;
      cfg_q.overlap   <= tef_pkg::RstOverlap;
      cfg_q.tile_rows <= tef_pkg::RstTileRows;
      cfg_q.tile_cols <= tef_pkg::RstTileCols;
    end else if (wr) begin
      case (idx)
        tef_pkg::RegTileSize: cfg_q.tile_size <= pwdata[tef_pkg::SizeW-1:0];
        tef_pkg::RegOverlap:  cfg_q.overlap   <= pwdata[tef_pkg::OvW-1:0];
        tef_pkg::RegTileRows: cfg_q.tile_rows <= pwdata[tef_pkg::GridW-1:0];
        tef_pkg::RegTileCols: cfg_q.tile_cols <= pwdata[tef_pkg::GridW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tef_pkg::RegTileSize: prdata = tef_pkg::DataW'(cfg_q.tile_size);
      tef_pkg::RegOverlap:  prdata = tef_pkg::DataW'(cfg_q.overlap);
      tef_pkg::RegTileRows: prdata = tef_pkg::DataW'(cfg_q.tile_rows);
      tef_pkg::RegTileCols: prdata = tef_pkg::DataW'(cfg_q.tile_cols);
      default:              prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/tef_front.sv
// tef_front: edge factor selection, weight numerator/denominator products and
// destination coordinates, three register stages. Depends on tef_pkg.
module tef_front (
  input  logic                                       clk_i,
  input  logic [tef_pkg::FrontStages-1:0]            en_i,
  input  tef_pkg::in_t                               in_i,
  input  tef_pkg::cfg_t                              cfg_i,
  output tef_pkg::ratio_t                            ratio_o,
  output tef_pkg::coord_t                            coord_o,
  output logic [tef_pkg::NumLanes-1:0][tef_pkg::ChanW-1:0] chan_o
);

  typedef struct packed {
    logic [tef_pkg::OvW-1:0] num;
    logic [tef_pkg::OvW-1:0] den;
  } factor_t;

  typedef logic [tef_pkg::NumLanes-1:0][tef_pkg::ChanW-1:0] chans_t;

  // left / top: (d + 1) / overlap
  function automatic factor_t near_fac(input logic [tef_pkg::PixW-1:0] pos,
                                       input logic [tef_pkg::OvW-1:0]  ov,
                                       input logic                     nb);
    factor_t f;
    f.num = tef_pkg::OvW'(1);
    f.den = tef_pkg::OvW'(1);
    if (nb && (tef_pkg::OvW'(pos) < ov)) begin
      f.num = tef_pkg::OvW'(pos) + tef_pkg::OvW'(1);
      f.den = ov;
    end
    return f;
  endfunction

  // right / bottom: d / overlap, d saturates to 0 outside the tile
  function automatic factor_t far_fac(input logic [tef_pkg::PixW-1:0]  pos,
                                      input logic [tef_pkg::SizeW-1:0] size,
                                      input logic [tef_pkg::OvW-1:0]   ov,
                                      input logic                      nb);
    factor_t                  f;
    logic [tef_pkg::SizeW-1:0] gap;
    gap = '0;
    if (tef_pkg::SizeW'(pos) < size) begin
      gap = size - tef_pkg::SizeW'(pos) - tef_pkg::SizeW'(1);
    end
    f.num = tef_pkg::OvW'(1);
    f.den = tef_pkg::OvW'(1);
    if (nb && (gap < tef_pkg::SizeW'(ov))) begin
      f.num = gap[tef_pkg::OvW-1:0];
      f.den = ov;
    end
    return f;
  endfunction

  logic [tef_pkg::SizeW-1:0]  size;
  logic [tef_pkg::GridW-1:0]  rows, cols;
  logic [tef_pkg::CoordW-1:0] step;
  logic                       nb_l, nb_r, nb_t, nb_b;
  factor_t [tef_pkg::NumFactors-1:0] fac_d;
  tef_pkg::coord_t            coord_d;
  chans_t                     chan_d;

  always_comb begin
    size = (32'(cfg_i.tile_size) > tef_pkg::MaxTile) ?
           tef_pkg::SizeW'(tef_pkg::MaxTile) : cfg_i.tile_size;
    rows = (32'(cfg_i.tile_rows) > tef_pkg::MaxGrid) ?
           tef_pkg::GridW'(tef_pkg::MaxGrid) : cfg_i.tile_rows;
    cols = (32'(cfg_i.tile_cols) > tef_pkg::MaxGrid) ?
           tef_pkg::GridW'(tef_pkg::MaxGrid) : cfg_i.tile_cols;
    nb_l = (in_i.tile_col != '0);
    nb_t = (in_i.tile_row != '0);
    nb_r = (tef_pkg::GridW'(in_i.tile_col) + tef_pkg::GridW'(1)) < cols;
    nb_b = (tef_pkg::GridW'(in_i.tile_row) + tef_pkg::GridW'(1)) < rows;
    fac_d[0] = near_fac(in_i.pix_x, cfg_i.overlap, nb_l);
    fac_d[1] = far_fac(in_i.pix_x, size, cfg_i.overlap, nb_r);
    fac_d[2] = near_fac(in_i.pix_y, cfg_i.overlap, nb_t);
    fac_d[3] = far_fac(in_i.pix_y, size, cfg_i.overlap, nb_b);
    step = tef_pkg::CoordW'(size) - tef_pkg::CoordW'(cfg_i.overlap);
    coord_d.dest_x = tef_pkg::CoordW'(tef_pkg::CoordW'(in_i.tile_col) * step)
                   + tef_pkg::CoordW'(in_i.pix_x);
    coord_d.dest_y = tef_pkg::CoordW'(tef_pkg::CoordW'(in_i.tile_row) * step)
                   + tef_pkg::CoordW'(in_i.pix_y);
    chan_d[0] = in_i.chan_a;
    chan_d[1] = in_i.chan_b;
    chan_d[2] = in_i.chan_c;
  end

  // stage 0: factors
  factor_t [tef_pkg::NumFactors-1:0] fac_q;
  tef_pkg::coord_t                   coord0_q;
  chans_t                            chan0_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      fac_q    <= fac_d;
      coord0_q <= coord_d;
      chan0_q  <= chan_d;
    end
  end

  // stage 1: pair products
  logic [tef_pkg::PairW-1:0] num01_q, num23_q, den01_q, den23_q;
  tef_pkg::coord_t           coord1_q;
  chans_t                    chan1_q;
  logic [tef_pkg::PairW-1:0] num01_d, num23_d, den01_d, den23_d;

  assign num01_d = fac_q[0].num * fac_q[1].num;
  assign num23_d = fac_q[2].num * fac_q[3].num;
  assign den01_d = fac_q[0].den * fac_q[1].den;
  assign den23_d = fac_q[2].den * fac_q[3].den;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      num01_q  <= num01_d;
      num23_q  <= num23_d;
      den01_q  <= den01_d;
      den23_q  <= den23_d;
      coord1_q <= coord0_q;
      chan1_q  <= chan0_q;
    end
  end

  // stage 2: full ratio
  tef_pkg::ratio_t ratio_q, ratio_d;
  tef_pkg::coord_t coord2_q;
  chans_t          chan2_q;

  assign ratio_d.num = num01_q * num23_q;
  assign ratio_d.den = den01_q * den23_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      ratio_q  <= ratio_d;
      coord2_q <= coord1_q;
      chan2_q  <= chan1_q;
    end
  end

  assign ratio_o = ratio_q;
  assign coord_o = coord2_q;
  assign chan_o  = chan2_q;

endmodule

>>> rtl/tef_lane.sv
// tef_lane: one channel lane, channel times ratio numerator followed by a
// pipelined restoring divider, one quotient bit per stage. Depends on tef_pkg.
module tef_lane (
  input  logic                           clk_i,
  input  logic [tef_pkg::LaneStages-1:0] en_i,
  input  logic [tef_pkg::ChanW-1:0]      chan_i,
  input  tef_pkg::ratio_t                ratio_i,
  output logic [tef_pkg::QuoW-1:0]       quo_o
);

  localparam int unsigned ProdW  = tef_pkg::ProdW;
  localparam int unsigned RatioW = tef_pkg::RatioW;
  localparam int unsigned QuoW   = tef_pkg::QuoW;

  logic [ProdW-1:0]  prod_d, prod_q;
  logic [RatioW-1:0] den0_q;

  assign prod_d = chan_i * ratio_i.num;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
      den0_q <= ratio_i.den;
    end
  end

  logic [ProdW-1:0]  rem_q [QuoW-1];
  logic [RatioW-1:0] den_q [QuoW-1];
  logic [QuoW-1:0]   quo_q [QuoW];

  for (genvar s = 0; s < QuoW; s++) begin : g_div
    logic [ProdW-1:0]  rem_in, sub;
    logic [RatioW-1:0] den_in;
    logic [QuoW-1:0]   quo_in, quo_out;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in = prod_q;
      assign den_in = den0_q;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign sub = ProdW'(den_in) << (QuoW - 1 - s);
    assign ge  = (rem_in >= sub);

    always_comb begin
      quo_out = quo_in;
      quo_out[QuoW-1-s] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s+1]) begin
        quo_q[s] <= quo_out;
      end
    end

    if (s < QuoW - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i[s+1]) begin
          rem_q[s] <= ge ? (rem_in - sub) : rem_in;
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule

>>> rtl/tef_merge.sv
// tef_merge: aligns destination coordinates with the lane results and holds
// the output register of the result channel. Depends on tef_pkg.
module tef_merge (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic [tef_pkg::LaneStages-1:0]                  en_i,
  input  logic                                            last_valid_i,
  input  tef_pkg::coord_t                                 coord_i,
  input  logic [tef_pkg::NumLanes-1:0][tef_pkg::QuoW-1:0] quo_i,
  input  logic                                            out_ready_i,
  output logic                                            out_valid_o,
  output tef_pkg::out_t                                   out_data_o
);

  tef_pkg::coord_t dly_q [tef_pkg::LaneStages];
  tef_pkg::out_t   out_q, out_d;
  logic            out_valid_q;
  logic            load;

  for (genvar k = 0; k < tef_pkg::LaneStages; k++) begin : g_dly
    if (k == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          dly_q[k] <= coord_i;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          dly_q[k] <= dly_q[k-1];
        end
      end
    end
  end

  assign load = !out_valid_q || out_ready_i;

  always_comb begin
    out_d.dest_x     = dly_q[tef_pkg::LaneStages-1].dest_x;
    out_d.dest_y     = dly_q[tef_pkg::LaneStages-1].dest_y;
    out_d.weighted_a = quo_i[0];
    out_d.weighted_b = quo_i[1];
    out_d.weighted_c = quo_i[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= last_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/tile_edge_feather_weight.sv
// tile_edge_feather_weight: top level of the feather weight pipeline, with
// config registers, front stages, three channel lanes and the merge stage.
// Depends on tef_pkg, tef_cfg, tef_front, tef_lane and tef_merge.
//
//   channel  | signals                          | transfer when
//   ---------+----------------------------------+-------------------------------
//   in       | in_valid_i in_ready_o in_data_i  | in_valid_i && in_ready_o
//   out      | out_valid_o out_ready_i out_data_o | out_valid_o && out_ready_i
//   config   | psel penable pwrite paddr pwdata | psel && penable && pwrite
//
// One pixel per cycle while the output is not stalled. An input transfer loads the first
// of 21 registers (3 front stages, a product stage and 16 divider stages per lane, then
// the output register), and out_valid_o rises once the pixel reaches the output register.
// Each stage has its own valid bit, so bubbles close up under
// an output stall and in_ready_o drops only when every stage is full.
// Reset clears valid bits and restores register defaults.
module tile_edge_feather_weight (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  tef_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output tef_pkg::out_t             out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tef_pkg::AddrW-1:0] paddr,
  input  logic [tef_pkg::DataW-1:0] pwdata,
  output logic [tef_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  localparam int unsigned PipeStages  = tef_pkg::PipeStages;
  localparam int unsigned FrontStages = tef_pkg::FrontStages;

  tef_pkg::cfg_t   cfg;
  tef_pkg::ratio_t ratio;
  tef_pkg::coord_t coord;
  logic [tef_pkg::NumLanes-1:0][tef_pkg::ChanW-1:0] chan;
  logic [tef_pkg::NumLanes-1:0][tef_pkg::QuoW-1:0]  quo;

  logic [PipeStages-1:0] v_q, v_up, en;
  logic [PipeStages:0]   free;
  logic                  out_valid;

  // stall chain: a stage loads when empty or when its content moves on
  assign free[PipeStages] = !out_valid || out_ready_i;
  for (genvar k = 0; k < PipeStages; k++) begin : g_free
    assign free[k] = !v_q[k] || free[k+1];
  end

  assign en   = free[PipeStages-1:0];
  assign v_up = {v_q[PipeStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < PipeStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_up[k];
        end
      end
    end
  end

  assign in_ready_o = free[0];

  tef_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tef_front u_front (
    .clk_i   (clk_i),
    .en_i    (en[FrontStages-1:0]),
    .in_i    (in_data_i),
    .cfg_i   (cfg),
    .ratio_o (ratio),
    .coord_o (coord),
    .chan_o  (chan)
  );

  for (genvar l = 0; l < tef_pkg::NumLanes; l++) begin : g_lane
    tef_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en[PipeStages-1:FrontStages]),
      .chan_i  (chan[l]),
      .ratio_i (ratio),
      .quo_o   (quo[l])
    );
  end

  tef_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en[PipeStages-1:FrontStages]),
    .last_valid_i (v_q[PipeStages-1]),
    .coord_i      (coord),
    .quo_i        (quo),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid),
    .out_data_o   (out_data_o)
  );

  assign out_valid_o = out_valid;

endmodule

>>> rtl/tef_checker.sv
// tef_checker: port-level assertions for tile_edge_feather_weight, bound to it.
// Depends on tef_pkg.
module tef_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input tef_pkg::out_t             out_data_o,
  input logic                      psel,
  input logic                      penable,
  input logic                      pwrite,
  input logic [tef_pkg::AddrW-1:0] paddr,
  input logic [tef_pkg::DataW-1:0] pwdata,
  input logic [tef_pkg::DataW-1:0] prdata,
  input logic                      pready
);

  localparam int unsigned CntW = $clog2(tef_pkg::PipeStages + 2) + 1;

  logic [CntW-1:0] inflight_q;
  logic            in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      inflight_q <= inflight_q + CntW'(1);
    end else if (out_xfer && !in_xfer) begin
      inflight_q <= inflight_q - CntW'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled while output register drains");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (inflight_q != '0) &&
                    (inflight_q <= CntW'(tef_pkg::PipeStages + 1)))
    else $error("result without matching input transfer");

  a_ov_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready &&
    (paddr[3:2] == 2'(tef_pkg::RegOverlap))
    |=> !$stable(paddr) ||
        (prdata == tef_pkg::DataW'($past(pwdata[tef_pkg::OvW-1:0]))))
    else $error("overlap register readback mismatch");

endmodule

bind tile_edge_feather_weight tef_checker u_tef_checker (.*);

>>> verif/tb.sv
// tb: self-checking testbench for tile_edge_feather_weight, with a pixel-level
// predictor of the feather weights and destination coordinates, APB writes and random stalls.
// Depends on tef_pkg and the tile_edge_feather_weight RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned SettleCycles = tef_pkg::PipeStages + 4;

  class feather_scoreboard;
    logic [tef_pkg::SizeW-1:0] tile_size;
    logic [tef_pkg::OvW-1:0]   overlap;
    logic [tef_pkg::GridW-1:0] tile_rows;
    logic [tef_pkg::GridW-1:0] tile_cols;
    tef_pkg::out_t             pending[$];
    int unsigned               errors;

    function new();
      tile_size = tef_pkg::RstTileSize;
      overlap   = tef_pkg::RstOverlap;
      tile_rows = tef_pkg::RstTileRows;
      tile_cols = tef_pkg::RstTileCols;
      errors    = 0;
    endfunction

    function void set_reg(tef_pkg::reg_idx_e idx, logic [tef_pkg::DataW-1:0] v);
      case (idx)
        tef_pkg::RegTileSize: tile_size = v[tef_pkg::SizeW-1:0];
        tef_pkg::RegOverlap:  overlap   = v[tef_pkg::OvW-1:0];
        tef_pkg::RegTileRows: tile_rows = v[tef_pkg::GridW-1:0];
        tef_pkg::RegTileCols: tile_cols = v[tef_pkg::GridW-1:0];
        default: ;
      endcase
    endfunction

    // near edge ramps (d+1)/ov, far edge ramps d/ov; far distance saturates at 0
    function void ramp_axis(logic [31:0] pos, logic [31:0] size, bit near_nb, bit far_nb,
                            inout logic [63:0] num, inout logic [63:0] den);
      logic [31:0] dist_far;
      dist_far = (pos < size) ? size - pos - 1 : 32'd0;
      if (near_nb && pos < 32'(overlap)) begin
        num = num * 64'(pos + 1);
        den = den * 64'(overlap);
      end
      if (far_nb && dist_far < 32'(overlap)) begin
        num = num * 64'(dist_far);
        den = den * 64'(overlap);
      end
    endfunction

    function tef_pkg::out_t feather_predict(tef_pkg::in_t px);
      logic [31:0]   size, rows, cols, pitch;
      logic [63:0]   num, den;
      tef_pkg::out_t r;
      size  = (32'(tile_size) > tef_pkg::MaxTile) ? tef_pkg::MaxTile : 32'(tile_size);
      rows  = (32'(tile_rows) > tef_pkg::MaxGrid) ? tef_pkg::MaxGrid : 32'(tile_rows);
      cols  = (32'(tile_cols) > tef_pkg::MaxGrid) ? tef_pkg::MaxGrid : 32'(tile_cols);
      pitch = size - 32'(overlap);
      num   = 64'd1;
      den   = 64'd1;
      ramp_axis(32'(px.pix_x), size, px.tile_col != 0, 32'(px.tile_col) + 1 < cols, num, den);
      ramp_axis(32'(px.pix_y), size, px.tile_row != 0, 32'(px.tile_row) + 1 < rows, num, den);
      r.dest_x     = 16'(32'(px.tile_col) * pitch + 32'(px.pix_x));
      r.dest_y     = 16'(32'(px.tile_row) * pitch + 32'(px.pix_y));
      r.weighted_a = 16'((64'(px.chan_a) * num) / den);
      r.weighted_b = 16'((64'(px.chan_b) * num) / den);
      r.weighted_c = 16'((64'(px.chan_c) * num) / den);
      return r;
    endfunction

    function void note_pixel(tef_pkg::in_t px);
      pending.insert(pending.size(), feather_predict(px));
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(tef_pkg::out_t got);
      tef_pkg::out_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transfer %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare("dest_x", want.dest_x, got.dest_x);
      compare("dest_y", want.dest_y, got.dest_y);
      compare("weighted_a", want.weighted_a, got.weighted_a);
      compare("weighted_b", want.weighted_b, got.weighted_b);
      compare("weighted_c", want.weighted_c, got.weighted_c);
    endfunction
  endclass

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  tef_pkg::in_t              in_data_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  tef_pkg::out_t             out_data_o;
  logic                      psel        = 1'b0;
  logic                      penable     = 1'b0;
  logic                      pwrite      = 1'b0;
  logic [tef_pkg::AddrW-1:0] paddr       = '0;
  logic [tef_pkg::DataW-1:0] pwdata      = '0;
  logic [tef_pkg::DataW-1:0] prdata;
  logic                      pready;

  bit                steady = 1'b0;
  int unsigned       cycles = 0;
  feather_scoreboard sb;

  tile_edge_feather_weight DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 28);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input tef_pkg::reg_idx_e idx,
                           input logic [tef_pkg::DataW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tef_pkg::AddrW'(4 * int'(idx));
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input tef_pkg::in_t px);
    if (!steady) begin
      while ($urandom_range(99) < 28) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(px);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [tef_pkg::TileIdxW-1:0] pick_index(int unsigned grid);
    int unsigned g;
    g = (grid > tef_pkg::MaxGrid) ? tef_pkg::MaxGrid : grid;
    if (g == 0 || $urandom_range(4) == 0) return tef_pkg::TileIdxW'($urandom_range(63));
    return tef_pkg::TileIdxW'($urandom_range(g - 1));
  endfunction

  // mostly inside the tile and near its edges, where the ramps live
  function automatic logic [tef_pkg::PixW-1:0] pick_pos(int unsigned eff, int unsigned ov);
    int unsigned band;
    band = (ov + 1 > 1023) ? 1023 : ov + 1;
    case ($urandom_range(9))
      0, 1: return tef_pkg::PixW'($urandom_range(1023));
      2, 3, 4: return tef_pkg::PixW'($urandom_range(band));
      5, 6, 7: begin
        if (eff != 0) begin
          return tef_pkg::PixW'(eff - 1 -
                                $urandom_range((band > eff - 1) ? eff - 1 : band));
        end
      end
      default: begin
        if (eff != 0) return tef_pkg::PixW'($urandom_range(eff - 1));
      end
    endcase
    return tef_pkg::PixW'($urandom_range(1023));
  endfunction

  function automatic logic [tef_pkg::ChanW-1:0] pick_chan();
    case ($urandom_range(9))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'h8000;
      default: return tef_pkg::ChanW'($urandom());
    endcase
  endfunction

  function automatic tef_pkg::in_t random_pixel(int unsigned size_v, int unsigned ov_v,
                                                int unsigned rows_v, int unsigned cols_v);
    tef_pkg::in_t px;
    int unsigned  eff;
    eff         = (size_v > tef_pkg::MaxTile) ? tef_pkg::MaxTile : size_v;
    px.tile_col = pick_index(cols_v);
    px.tile_row = pick_index(rows_v);
    px.pix_x    = pick_pos(eff, ov_v);
    px.pix_y    = pick_pos(eff, ov_v);
    px.chan_a   = pick_chan();
    px.chan_b   = pick_chan();
    px.chan_c   = pick_chan();
    return px;
  endfunction

  function automatic tef_pkg::in_t pixel(int unsigned tc, int unsigned tr, int unsigned x,
                                         int unsigned y, logic [15:0] a, logic [15:0] b,
                                         logic [15:0] c);
    tef_pkg::in_t px;
    px.tile_col = tef_pkg::TileIdxW'(tc);
    px.tile_row = tef_pkg::TileIdxW'(tr);
    px.pix_x    = tef_pkg::PixW'(x);
    px.pix_y    = tef_pkg::PixW'(y);
    px.chan_a   = a;
    px.chan_b   = b;
    px.chan_c   = c;
    return px;
  endfunction

  // junk above the field width must be dropped by the register
  task automatic load_config(input int unsigned size_v, input int unsigned ov_v,
                             input int unsigned rows_v, input int unsigned cols_v,
                             input bit junk);
    settle();
    write_reg(tef_pkg::RegTileSize,
              tef_pkg::DataW'(size_v) | (junk ? ($urandom() << tef_pkg::SizeW) : '0));
    write_reg(tef_pkg::RegOverlap,
              tef_pkg::DataW'(ov_v) | (junk ? ($urandom() << tef_pkg::OvW) : '0));
    write_reg(tef_pkg::RegTileRows,
              tef_pkg::DataW'(rows_v) | (junk ? ($urandom() << tef_pkg::GridW) : '0));
    write_reg(tef_pkg::RegTileCols,
              tef_pkg::DataW'(cols_v) | (junk ? ($urandom() << tef_pkg::GridW) : '0));
  endtask

  task automatic run_phase(input int unsigned size_v, input int unsigned ov_v,
                           input int unsigned rows_v, input int unsigned cols_v,
                           input int unsigned count, input bit junk);
    load_config(size_v, ov_v, rows_v, cols_v, junk);
    for (int unsigned i = 0; i < count; i++) begin
      if (count >= 100 && i == count / 2) settle();
      send_pixel(random_pixel(size_v, ov_v, rows_v, cols_v));
    end
  endtask

  initial begin
    int unsigned sz;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: single tile, no right or bottom neighbors
    repeat (20) send_pixel(random_pixel(tef_pkg::RstTileSize, tef_pkg::RstOverlap,
                                        tef_pkg::RstTileRows, tef_pkg::RstTileCols));

    // 3x3 grid, 16-pixel tiles, 4-pixel band
    load_config(16, 4, 3, 3, 1'b0);
    send_pixel(pixel(1, 1, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pixel(1, 1, 3, 3, 16'hFFFF, 16'h8000, 16'h0001));
    send_pixel(pixel(1, 1, 4, 4, 16'hFFFF, 16'h1234, 16'h7FFF));
    send_pixel(pixel(1, 1, 15, 15, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pixel(1, 1, 12, 12, 16'hFFFF, 16'h8000, 16'h0003));
    send_pixel(pixel(1, 1, 11, 11, 16'hFFFF, 16'hABCD, 16'h0001));
    send_pixel(pixel(1, 1, 0, 15, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pixel(1, 1, 15, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pixel(0, 0, 0, 0, 16'hFFFF, 16'h8000, 16'h0000));
    send_pixel(pixel(2, 2, 15, 15, 16'hFFFF, 16'h8000, 16'h5555));
    send_pixel(pixel(1, 1, 1023, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pixel(63, 63, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pixel(63, 63, 1023, 1023, 16'hFFFF, 16'hAAAA, 16'h5555));
    send_pixel(pixel(0, 1, 2, 13, 16'h0000, 16'h0000, 16'h0000));
    send_pixel(pixel(1, 0, 13, 2, 16'h7FFF, 16'h8000, 16'hFFFF));
    send_pixel(pixel(1, 1, 7, 7, 16'hAAAA, 16'h5555, 16'hFFFF));

    steady = 1'b1;
    run_phase(64, 16, 4, 4, 120, 1'b0);
    steady = 1'b0;
    run_phase(8, 8, 2, 2, 100, 1'b1);
    run_phase(1024, 512, 64, 64, 100, 1'b0);
    settle();
    send_pixel(pixel(63, 63, 1023, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pixel(32, 32, 511, 512, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    run_phase(2047, 1023, 127, 127, 100, 1'b1);
    run_phase(32, 0, 5, 5, 100, 1'b0);
    run_phase(0, 3, 2, 2, 80, 1'b1);
    run_phase(1, 1, 0, 0, 80, 1'b0);
    repeat (2) begin
      sz = $urandom_range(64, 1);
      run_phase(sz, $urandom_range(sz), $urandom_range(8, 1), $urandom_range(8, 1), 100, 1'b1);
    end

    settle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/tef_pkg.sv
rtl/tef_cfg.sv
rtl/tef_front.sv
rtl/tef_lane.sv
rtl/tef_merge.sv
rtl/tile_edge_feather_weight.sv
rtl/tef_checker.sv
verif/tb.sv
